>>> sv/secondary_photon_tracking_table_defines.svh
// Assertion macros for the photon tracking table.
`ifndef SECONDARY_PHOTON_TRACKING_TABLE_DEFINES_SVH
`define SECONDARY_PHOTON_TRACKING_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SPT_ASSERT_CK(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
`define SPT_ASSERT(lbl, prop, msg) `SPT_ASSERT_CK(lbl, clk, arst_n, prop, msg)
`else
`define SPT_ASSERT_CK(lbl, ck, rstn, prop, msg)
`define SPT_ASSERT(lbl, prop, msg)
`endif

`endif

>>> sv/spt_pkg.sv
// Shared types and constants of the photon tracking table.
`timescale 1ns / 1ps

package spt_pkg;

	localparam int TABLE_ENTRIES = 16;

	localparam logic [23:0] PARENT_PRIMARY = 24'd1;

	localparam logic [1:0] KIND_STEP  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [2:0] ST_NONE     = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_UPDATED  = 3'd2;
	localparam logic [2:0] ST_ACCUM    = 3'd3;
	localparam logic [2:0] ST_DROPPED  = 3'd4;

	typedef enum logic [1:0] {
		MODE_PHOTON,
		MODE_MARKER,
		MODE_DAUGHTER,
		MODE_READ
	} mode_t;

	typedef struct packed {
		logic [23:0]        particle;
		logic signed [15:0] volume;
		logic [23:0]        energy;
		logic [31:0]        loss;
		logic [15:0]        hits;
	} entry_t;

	typedef struct packed {
		mode_t              mode;
		logic               in_use;
		logic               at_tail;
		logic               found;
		logic signed [15:0] carry;
		logic [23:0]        pid;
		logic [23:0]        par;
		logic signed [7:0]  ptype;
		logic [14:0]        vol;
		logic [23:0]        ene;
		logic [23:0]        loss;
	} upd_in_t;

	typedef struct packed {
		logic               match;
		logic               append;
		logic signed [15:0] carry;
	} upd_out_t;

endpackage

>>> sv/spt_cell.sv
// One table cell: holds one entry and passes it on along the ring.
`timescale 1ns / 1ps

module spt_cell (
	input  logic            clk,
	input  logic            shift,
	input  spt_pkg::entry_t d,
	output spt_pkg::entry_t q
);

	spt_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

>>> sv/spt_update.sv
// Head unit: matches and rewrites the entry leaving the ring head.
`timescale 1ns / 1ps

module spt_update (
	input  spt_pkg::entry_t  head,
	input  spt_pkg::upd_in_t ctl,
	output spt_pkg::entry_t  nxt,
	output spt_pkg::upd_out_t res
);

	logic [32:0]        loss_sum;
	logic signed [15:0] carry_new;
	logic               ph_match;
	logic               dt_match;
	logic               app;

	always_comb begin
		loss_sum  = {1'b0, head.loss} + 33'(ctl.loss);
		carry_new = (head.hits != 16'd0) ? head.volume : ctl.carry;
		ph_match  = (ctl.mode == spt_pkg::MODE_PHOTON) && ctl.in_use && !ctl.found
			&& (head.particle == ctl.pid) && (head.volume > 16'sd0);
		dt_match  = (ctl.mode == spt_pkg::MODE_DAUGHTER) && ctl.in_use
			&& (head.particle == ctl.par);
		app       = ctl.at_tail && (((ctl.mode == spt_pkg::MODE_PHOTON) && !ctl.found)
			|| (ctl.mode == spt_pkg::MODE_MARKER));

		nxt       = head;
		res.match = ph_match || dt_match;
		res.append = app;
		res.carry = ctl.carry;

		if (ph_match) begin
			nxt.volume = $signed({1'b0, ctl.vol});
		end
		if (dt_match) begin
			res.carry  = carry_new;
			nxt.volume = carry_new;
			nxt.loss   = loss_sum[32] ? 32'hFFFF_FFFF : loss_sum[31:0];
			nxt.hits   = (head.hits == 16'hFFFF) ? head.hits : head.hits + 16'd1;
		end
		if (app) begin
			nxt.particle = ctl.pid;
			nxt.volume   = (ctl.mode == spt_pkg::MODE_PHOTON) ? $signed({1'b0, ctl.vol})
				: 16'(ctl.ptype);
			nxt.energy   = ctl.ene;
			nxt.loss     = '0;
			nxt.hits     = '0;
		end
	end

endmodule

>>> sv/secondary_photon_tracking_table.sv
// Top level: ring of table cells, head update unit and item sequencer.
// Steps that search the table and read out of a filled table hold busy for one ring turn;
// no new item is accepted while busy. Clear, ignored words, empty read out and steps
// answered at once keep busy low and may follow every cycle. Results cannot be stalled.
// arst_n clears the fill count, the threshold and all control; cell contents stay unknown.
`timescale 1ns / 1ps
`include "secondary_photon_tracking_table_defines.svh"

module secondary_photon_tracking_table #(
	parameter int TABLE_ENTRIES = spt_pkg::TABLE_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               min_energy_we,
	input  logic [23:0]        min_energy,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [23:0]        track_id,
	input  logic [23:0]        parent_id,
	input  logic signed [7:0]  particle_type,
	input  logic [14:0]        step_volume,
	input  logic [23:0]        energy,
	input  logic [23:0]        energy_loss,
	output logic               strobe,
	output logic [2:0]         status,
	output logic               entry_valid,
	output logic [23:0]        entry_particle,
	output logic signed [15:0] entry_volume,
	output logic [23:0]        entry_energy,
	output logic [31:0]        entry_loss,
	output logic [15:0]        entry_hits,
	output logic               last
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] IDX_END = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic {S_IDLE, S_WALK} state_t;

	state_t              state_q;
	spt_pkg::mode_t      mode_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    used_q;
	logic [23:0]         min_energy_q;
	logic                found_q;
	logic                app_q;
	logic signed [15:0]  carry_q;
	logic [23:0]         pid_q;
	logic [23:0]         par_q;
	logic signed [7:0]   ptype_q;
	logic [14:0]         vol_q;
	logic [23:0]         ene_q;
	logic [23:0]         loss_q;

	logic                strobe_q;
	logic [2:0]          status_q;
	logic                entry_valid_q;
	spt_pkg::entry_t     entry_q;
	logic                last_q;

	spt_pkg::entry_t     cell_q [TABLE_ENTRIES];
	spt_pkg::entry_t     upd_entry;
	spt_pkg::upd_in_t    upd_in;
	spt_pkg::upd_out_t   upd_out;

	logic                walking;
	logic [CNT_W-1:0]    idx_ext;
	logic                found_nxt;
	logic                app_nxt;
	logic                photon_ok;

	assign walking   = (state_q == S_WALK);
	assign idx_ext   = CNT_W'(idx_q);
	assign found_nxt = found_q || upd_out.match;
	assign app_nxt   = app_q || upd_out.append;
	assign photon_ok = (track_id != spt_pkg::PARENT_PRIMARY)
		&& (parent_id == spt_pkg::PARENT_PRIMARY) && (energy > min_energy_q);

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			spt_pkg::entry_t cell_d;
			if (gi == TABLE_ENTRIES - 1) begin : g_tail
				assign cell_d = upd_entry;
			end else begin : g_mid
				assign cell_d = cell_q[gi + 1];
			end
			spt_cell u_cell (
				.clk   (clk),
				.shift (walking),
				.d     (cell_d),
				.q     (cell_q[gi])
			);
		end
	endgenerate

	always_comb begin
		upd_in.mode    = mode_q;
		upd_in.in_use  = idx_ext < used_q;
		upd_in.at_tail = idx_ext == used_q;
		upd_in.found   = found_q;
		upd_in.carry   = carry_q;
		upd_in.pid     = pid_q;
		upd_in.par     = par_q;
		upd_in.ptype   = ptype_q;
		upd_in.vol     = vol_q;
		upd_in.ene     = ene_q;
		upd_in.loss    = loss_q;
	end

	spt_update u_update (
		.head (cell_q[0]),
		.ctl  (upd_in),
		.nxt  (upd_entry),
		.res  (upd_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mode_q        <= spt_pkg::MODE_READ;
			idx_q         <= '0;
			used_q        <= '0;
			min_energy_q  <= '0;
			found_q       <= 1'b0;
			app_q         <= 1'b0;
			carry_q       <= '0;
			pid_q         <= '0;
			par_q         <= '0;
			ptype_q       <= '0;
			vol_q         <= '0;
			ene_q         <= '0;
			loss_q        <= '0;
			strobe_q      <= 1'b0;
			status_q      <= spt_pkg::ST_NONE;
			entry_valid_q <= 1'b0;
			entry_q       <= '0;
			last_q        <= 1'b0;
		end else begin
			strobe_q      <= 1'b0;
			status_q      <= spt_pkg::ST_NONE;
			entry_valid_q <= 1'b0;
			entry_q       <= '0;
			last_q        <= 1'b0;
			if (min_energy_we) begin
				min_energy_q <= min_energy;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						app_q   <= 1'b0;
						carry_q <= $signed({1'b0, step_volume});
						pid_q   <= track_id;
						par_q   <= parent_id;
						ptype_q <= particle_type;
						vol_q   <= step_volume;
						ene_q   <= energy;
						loss_q  <= energy_loss;
						priority if (kind == spt_pkg::KIND_CLEAR) begin
							used_q   <= '0;
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
						end else if (kind == spt_pkg::KIND_READ) begin
							if (used_q == '0) begin
								strobe_q <= 1'b1;
								last_q   <= 1'b1;
							end else begin
								mode_q  <= spt_pkg::MODE_READ;
								state_q <= S_WALK;
							end
						end else if (kind == spt_pkg::KIND_STEP) begin
							priority if (particle_type == 8'sd0) begin
								if (photon_ok) begin
									mode_q  <= spt_pkg::MODE_PHOTON;
									state_q <= S_WALK;
								end else begin
									strobe_q <= 1'b1;
									last_q   <= 1'b1;
								end
							end else if (particle_type[7]) begin
								mode_q  <= spt_pkg::MODE_MARKER;
								state_q <= S_WALK;
							end else if (parent_id == spt_pkg::PARENT_PRIMARY) begin
								strobe_q <= 1'b1;
								last_q   <= 1'b1;
							end else begin
								mode_q  <= spt_pkg::MODE_DAUGHTER;
								state_q <= S_WALK;
							end
						end else begin
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
						end
					end
				end
				S_WALK: begin
					idx_q   <= (idx_q == IDX_END) ? '0 : idx_q + IDX_W'(1);
					found_q <= found_nxt;
					app_q   <= app_nxt;
					carry_q <= upd_out.carry;
					if (mode_q == spt_pkg::MODE_READ && upd_in.in_use) begin
						strobe_q      <= 1'b1;
						entry_valid_q <= 1'b1;
						entry_q       <= cell_q[0];
						last_q        <= idx_ext == used_q - CNT_W'(1);
					end
					if (idx_q == IDX_END) begin
						state_q <= S_IDLE;
						if (mode_q != spt_pkg::MODE_READ) begin
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
							if (app_nxt) begin
								used_q <= used_q + CNT_W'(1);
							end
							unique case (mode_q)
								spt_pkg::MODE_DAUGHTER:
									status_q <= found_nxt ? spt_pkg::ST_ACCUM : spt_pkg::ST_NONE;
								spt_pkg::MODE_PHOTON:
									status_q <= found_nxt ? spt_pkg::ST_UPDATED
										: (app_nxt ? spt_pkg::ST_INSERTED : spt_pkg::ST_DROPPED);
								default:
									status_q <= app_nxt ? spt_pkg::ST_INSERTED
										: spt_pkg::ST_DROPPED;
							endcase
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy           = walking;
	assign strobe         = strobe_q;
	assign status         = status_q;
	assign entry_valid    = entry_valid_q;
	assign entry_particle = entry_q.particle;
	assign entry_volume   = entry_q.volume;
	assign entry_energy   = entry_q.energy;
	assign entry_loss     = entry_q.loss;
	assign entry_hits     = entry_q.hits;
	assign last           = last_q;

	`SPT_ASSERT(a_used_bound, used_q <= CNT_W'(TABLE_ENTRIES), "fill count beyond table size")
	`SPT_ASSERT(a_used_step, used_q != $past(used_q) |-> used_q == '0 || used_q == $past(used_q) + CNT_W'(1), "fill count jumped")
	`SPT_ASSERT(a_read_walks, start && !busy && kind == spt_pkg::KIND_READ && used_q != '0 |=> busy, "read out of filled table did not walk")
	`SPT_ASSERT(a_entry_strobe, entry_valid |-> strobe && status == spt_pkg::ST_NONE, "entry word without strobe")

endmodule
